// ===== sv/ildd_pkg.sv =====
// Shared constants, types and helpers for the loop direction detector.
package ildd_pkg;

    localparam int WINDOWS   = 3;
    localparam int SLOT_W    = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
    localparam int TUNE_W    = $clog2(WINDOWS + 1);
    localparam int FREQ_W    = 20;
    localparam int CNT_W     = 15;
    localparam int WIN_W     = 24;
    localparam int TIME_W    = 48;
    localparam int THR_W     = 16;
    localparam int NET_W     = 32;
    // count * 1e6 fits in 35 bits
    localparam int NUM_W     = 35;
    localparam int DIV_CYC   = NUM_W;
    localparam int DIVCNT_W  = $clog2(DIV_CYC + 1);
    localparam int SUM_W     = FREQ_W + $clog2(WINDOWS + 1) + 1;
    localparam int CMP_W     = SUM_W + THR_W + 1;
    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
    localparam logic [NUM_W-1:0]  SCALE_HZ = NUM_W'(1000000);

    localparam int CFG_W = 24;
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_STALE     = 2'd1;
    localparam logic [1:0] REG_HOLDOFF   = 2'd2;
    localparam logic [1:0] REG_A_ENTRY   = 2'd3;

    typedef enum logic [1:0] {
        LOOP_A    = 2'd0,
        LOOP_B    = 2'd1,
        LOOP_NONE = 2'd2
    } loop_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_AB   = 2'd1,
        DIR_BA   = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EVAL,
        ST_OUT
    } state_t;

    // lane result handed to the merging stage
    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic              hit;
    } lane_res_t;

endpackage

// ===== sv/ildd_lane.sv =====
// One loop lane: serial frequency divider, tuning ring and deviation test.
module ildd_lane (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic                          eval,
    input  logic                          tuning_item,
    input  logic                          tune_last,
    input  logic [ildd_pkg::TUNE_W-1:0]   tune_idx,
    input  logic [ildd_pkg::SLOT_W-1:0]   slot,
    input  logic [ildd_pkg::CNT_W-1:0]    count,
    input  logic [ildd_pkg::WIN_W-1:0]    window_us,
    input  logic [ildd_pkg::THR_W-1:0]    threshold,
    output logic                          done,
    output ildd_pkg::lane_res_t           res
);
    logic [ildd_pkg::NUM_W-1:0]    quo_reg, quo_next;
    logic [ildd_pkg::WIN_W:0]      rem_reg, rem_next;
    logic [ildd_pkg::WIN_W-1:0]    div_reg;
    logic [ildd_pkg::DIVCNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic [ildd_pkg::FREQ_W-1:0]   ring_reg [ildd_pkg::WINDOWS];
    logic [ildd_pkg::FREQ_W-1:0]   freq;
    logic [ildd_pkg::SUM_W-1:0]    sum;
    logic [ildd_pkg::CMP_W-1:0]    lhs, rhs;
    logic [ildd_pkg::WIN_W:0]      trial;

    // restoring divider, one quotient bit per cycle
    always_comb begin
        rem_next = {rem_reg[ildd_pkg::WIN_W-1:0], quo_reg[ildd_pkg::NUM_W-1]};
        quo_next = {quo_reg[ildd_pkg::NUM_W-2:0], 1'b0};
        trial    = rem_next - {1'b0, div_reg};
        if (rem_next >= {1'b0, div_reg}) begin
            rem_next    = trial;
            quo_next[0] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            quo_reg  <= ildd_pkg::NUM_W'(count) * ildd_pkg::SCALE_HZ;
            rem_reg  <= '0;
            div_reg  <= window_us;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == ildd_pkg::DIVCNT_W'(ildd_pkg::DIV_CYC - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign done = !busy_reg;

    always_comb begin
        if (div_reg == '0 || quo_reg > ildd_pkg::NUM_W'(ildd_pkg::FREQ_MAX)) begin
            freq = ildd_pkg::FREQ_MAX;
        end else begin
            freq = quo_reg[ildd_pkg::FREQ_W-1:0];
        end
        sum = '0;
        for (int i = 0; i < ildd_pkg::WINDOWS; i++) begin
            sum = sum + ildd_pkg::SUM_W'(ring_reg[i]);
        end
        lhs = ildd_pkg::CMP_W'(freq) * ildd_pkg::CMP_W'(ildd_pkg::WINDOWS);
        rhs = ildd_pkg::CMP_W'(sum)
            + ildd_pkg::CMP_W'(threshold) * ildd_pkg::CMP_W'(ildd_pkg::WINDOWS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ildd_pkg::WINDOWS; i++) begin
                ring_reg[i] <= '0;
            end
            res.hit <= 1'b0;
        end else if (eval) begin
            res.freq <= freq;
            if (tuning_item) begin
                res.hit <= 1'b0;
                for (int i = 0; i < ildd_pkg::WINDOWS; i++) begin
                    if (ildd_pkg::TUNE_W'(i) == tune_idx) begin
                        ring_reg[i] <= freq;
                    end
                end
                // last tuning value also lands in slot 0
                if (tune_last) begin
                    ring_reg[0] <= freq;
                end
            end else begin
                res.hit <= lhs > rhs;
                for (int i = 0; i < ildd_pkg::WINDOWS; i++) begin
                    if (ildd_pkg::SLOT_W'(i) == slot) begin
                        ring_reg[i] <= freq;
                    end
                end
            end
        end
    end

    busy_no_start: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !start) else $error("lane restarted while dividing");
    cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= ildd_pkg::DIVCNT_W'(ildd_pkg::DIV_CYC))
        else $error("divider count out of range");
    start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg) else $error("divider did not start");

endmodule

// ===== sv/ildd_dir.sv =====
// Direction logic: pairs loop events into passes and keeps the net count.
module ildd_dir (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic                         hit_a,
    input  logic                         hit_b,
    input  logic [ildd_pkg::TIME_W-1:0]  now_us,
    input  logic [ildd_pkg::WIN_W-1:0]   stale_us,
    input  logic [ildd_pkg::WIN_W-1:0]   holdoff_us,
    input  logic                         a_entry,
    output ildd_pkg::dir_t               dir,
    output logic [ildd_pkg::NET_W-1:0]   net
);
    ildd_pkg::loop_t              last_loop_reg, last_loop_next;
    logic [ildd_pkg::TIME_W-1:0]  last_evt_reg, last_evt_next;
    logic [ildd_pkg::TIME_W-1:0]  last_chg_reg, last_chg_next;
    logic [ildd_pkg::NET_W-1:0]   net_reg, net_next;
    ildd_pkg::dir_t               dir_next;
    logic [ildd_pkg::TIME_W-1:0]  gap, since;
    ildd_pkg::loop_t              lp;
    logic                         ok;

    // evaluates A then B in one combinational pass (two dependent steps)
    always_comb begin
        last_loop_next = last_loop_reg;
        last_evt_next  = last_evt_reg;
        last_chg_next  = last_chg_reg;
        net_next       = net_reg;
        dir_next       = ildd_pkg::DIR_NONE;
        gap            = '0;
        since          = '0;
        ok             = 1'b0;
        lp             = ildd_pkg::LOOP_A;
        for (int k = 0; k < 2; k++) begin
            if (k == 0) begin
                lp = ildd_pkg::LOOP_A;
            end else begin
                lp = ildd_pkg::LOOP_B;
            end
            if ((k == 0) ? hit_a : hit_b) begin
                gap   = now_us - last_evt_next;
                since = now_us - last_chg_next;
                ok    = since > ildd_pkg::TIME_W'(holdoff_us);
                if (lp != last_loop_next && gap < ildd_pkg::TIME_W'(stale_us)) begin
                    if (ok && last_loop_next == ildd_pkg::LOOP_A
                        && lp == ildd_pkg::LOOP_B) begin
                        net_next       = a_entry ? net_next + 1'b1 : net_next - 1'b1;
                        dir_next       = ildd_pkg::DIR_AB;
                        last_chg_next  = now_us;
                        last_evt_next  = now_us;
                    end else if (ok && last_loop_next == ildd_pkg::LOOP_B
                        && lp == ildd_pkg::LOOP_A) begin
                        net_next       = a_entry ? net_next - 1'b1 : net_next + 1'b1;
                        dir_next       = ildd_pkg::DIR_BA;
                        last_chg_next  = now_us;
                        last_evt_next  = now_us;
                    end
                end else begin
                    last_evt_next = now_us;
                end
                last_loop_next = lp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_loop_reg <= ildd_pkg::LOOP_NONE;
            last_evt_reg  <= '0;
            last_chg_reg  <= '0;
            net_reg       <= '0;
            dir           <= ildd_pkg::DIR_NONE;
        end else if (step) begin
            last_loop_reg <= last_loop_next;
            last_evt_reg  <= last_evt_next;
            last_chg_reg  <= last_chg_next;
            net_reg       <= net_next;
            dir           <= dir_next;
        end
    end

    assign net = net_reg;

    net_moves_with_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(step) && $past(dir_next) == ildd_pkg::DIR_NONE |-> $stable(net_reg))
        else $error("net count changed without a pass");
    no_hit_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !hit_a && !hit_b |=> $stable(last_loop_reg) && $stable(net_reg))
        else $error("state changed without an event");
    pass_sets_change: assert property (@(posedge aclk) disable iff (!aresetn)
        step && dir_next != ildd_pkg::DIR_NONE |=> last_chg_reg == last_evt_reg)
        else $error("pass did not stamp change time");

endmodule

// ===== sv/inductive_loop_direction_detector_core.sv =====
// Top level of the two-loop vehicle direction detector.
// Each item is one sample window for loops A and B. Two lanes each run a
// 35-step restoring divider (count * 1e6 / window_us, saturated to 20 bits).
// The result passes the divider, then the ring/threshold step (ST_DIV to
// ST_EVAL) and the direction step (ST_EVAL to ST_OUT); m_valid comes
// straight from the state register. The block takes one item at a time; the
// next item can be accepted in the cycle after the result is taken. The first
// WINDOWS items only fill the rings and report tuning. Configuration writes
// take effect at once and are meant to happen while no item is in flight.
module inductive_loop_direction_detector_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [ildd_pkg::CFG_W-1:0]   cfg_data,
    // input item channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ildd_pkg::CNT_W-1:0]   s_count_a,
    input  logic [ildd_pkg::CNT_W-1:0]   s_count_b,
    input  logic [ildd_pkg::WIN_W-1:0]   s_window_a_us,
    input  logic [ildd_pkg::WIN_W-1:0]   s_window_b_us,
    input  logic [ildd_pkg::TIME_W-1:0]  s_now_us,
    // result item channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ildd_pkg::FREQ_W-1:0]  m_freq_a_hz,
    output logic [ildd_pkg::FREQ_W-1:0]  m_freq_b_hz,
    output logic                         m_hit_a,
    output logic                         m_hit_b,
    output logic [1:0]                   m_direction,
    output logic signed [ildd_pkg::NET_W-1:0] m_delta_count,
    output logic                         m_tuning
);
    // config registers
    logic [ildd_pkg::THR_W-1:0]  thr_reg;
    logic [ildd_pkg::WIN_W-1:0]  stale_reg;
    logic [ildd_pkg::WIN_W-1:0]  hold_reg;
    logic                        a_entry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= ildd_pkg::THR_W'(150);
            stale_reg   <= ildd_pkg::WIN_W'(2000000);
            hold_reg    <= ildd_pkg::WIN_W'(250000);
            a_entry_reg <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ildd_pkg::REG_THRESHOLD: thr_reg   <= cfg_data[ildd_pkg::THR_W-1:0];
                ildd_pkg::REG_STALE:     stale_reg <= cfg_data;
                ildd_pkg::REG_HOLDOFF:   hold_reg  <= cfg_data;
                ildd_pkg::REG_A_ENTRY:   a_entry_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    ildd_pkg::state_t state_reg, state_next;
    logic [ildd_pkg::TIME_W-1:0] now_reg;
    logic [ildd_pkg::TUNE_W-1:0] tune_reg;
    logic [ildd_pkg::SLOT_W-1:0] slot_reg;
    logic                        tuning_item;
    logic                        tune_last;
    logic                        start, eval, dir_step, done_a, done_b;
    ildd_pkg::lane_res_t         res_a, res_b;
    ildd_pkg::dir_t              dir;
    logic [ildd_pkg::NET_W-1:0]  net;
    logic                        tuned_reg;

    assign tuning_item = tune_reg < ildd_pkg::TUNE_W'(ildd_pkg::WINDOWS);
    assign tune_last   = tune_reg == ildd_pkg::TUNE_W'(ildd_pkg::WINDOWS - 1);

    always_comb begin
        state_next = state_reg;
        start      = 1'b0;
        eval       = 1'b0;
        dir_step   = 1'b0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ildd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    start      = 1'b1;
                    state_next = ildd_pkg::ST_DIV;
                end
            end
            ildd_pkg::ST_DIV: begin
                // the lanes already report busy on entry to ST_DIV
                if (done_a && done_b) begin
                    eval       = 1'b1;
                    state_next = ildd_pkg::ST_EVAL;
                end
            end
            ildd_pkg::ST_EVAL: begin
                dir_step   = !tuned_reg;
                state_next = ildd_pkg::ST_OUT;
            end
            ildd_pkg::ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ildd_pkg::ST_IDLE;
                end
            end
            default: state_next = ildd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ildd_pkg::ST_IDLE;
            tune_reg  <= '0;
            slot_reg  <= '0;
            tuned_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (eval) begin
                tuned_reg <= tuning_item;
                if (tuning_item) begin
                    tune_reg <= tune_reg + 1'b1;
                    slot_reg <= '0;
                end else if (slot_reg == ildd_pkg::SLOT_W'(ildd_pkg::WINDOWS - 1)) begin
                    slot_reg <= '0;
                end else begin
                    slot_reg <= slot_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            now_reg <= s_now_us;
        end
    end

    ildd_lane u_lane_a (
        .aclk(aclk), .aresetn(aresetn), .start(start), .eval(eval),
        .tuning_item(tuning_item), .tune_last(tune_last), .tune_idx(tune_reg),
        .slot(slot_reg), .count(s_count_a), .window_us(s_window_a_us),
        .threshold(thr_reg), .done(done_a), .res(res_a)
    );

    ildd_lane u_lane_b (
        .aclk(aclk), .aresetn(aresetn), .start(start), .eval(eval),
        .tuning_item(tuning_item), .tune_last(tune_last), .tune_idx(tune_reg),
        .slot(slot_reg), .count(s_count_b), .window_us(s_window_b_us),
        .threshold(thr_reg), .done(done_b), .res(res_b)
    );

    // merging stage: both lanes' hits drive the shared direction logic
    ildd_dir u_dir (
        .aclk(aclk), .aresetn(aresetn), .step(dir_step),
        .hit_a(res_a.hit), .hit_b(res_b.hit), .now_us(now_reg),
        .stale_us(stale_reg), .holdoff_us(hold_reg), .a_entry(a_entry_reg),
        .dir(dir), .net(net)
    );

    // result fields are stable through ST_OUT; dir is only fresh after a step
    logic dir_fresh_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_fresh_reg <= 1'b0;
        end else if (state_reg == ildd_pkg::ST_EVAL) begin
            dir_fresh_reg <= dir_step;
        end
    end

    assign m_freq_a_hz   = res_a.freq;
    assign m_freq_b_hz   = res_b.freq;
    assign m_hit_a       = res_a.hit;
    assign m_hit_b       = res_b.hit;
    assign m_direction   = dir_fresh_reg ? dir : ildd_pkg::DIR_NONE;
    assign m_delta_count = net;
    assign m_tuning      = tuned_reg;

    tuning_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tuning |-> !m_hit_a && !m_hit_b)
        else $error("hit reported while tuning");
    one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("input taken with a result pending");
    slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= ildd_pkg::SLOT_W'(ildd_pkg::WINDOWS - 1))
        else $error("ring slot out of range");

endmodule

// ===== tb/tb_inductive_loop_direction_detector_core.sv =====
// Testbench for the two-loop direction detector, checked against a predictor.
`timescale 1ns / 1ps

module tb_inductive_loop_direction_detector_core;

    localparam int WDOG_LIMIT = 20000;

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_we;
    logic [1:0]                       cfg_index;
    logic [ildd_pkg::CFG_W-1:0]       cfg_data;
    logic                             s_valid;
    logic                             s_ready;
    logic [ildd_pkg::CNT_W-1:0]       s_count_a;
    logic [ildd_pkg::CNT_W-1:0]       s_count_b;
    logic [ildd_pkg::WIN_W-1:0]       s_window_a_us;
    logic [ildd_pkg::WIN_W-1:0]       s_window_b_us;
    logic [ildd_pkg::TIME_W-1:0]      s_now_us;
    logic                             m_valid;
    logic                             m_ready;
    logic [ildd_pkg::FREQ_W-1:0]      m_freq_a_hz;
    logic [ildd_pkg::FREQ_W-1:0]      m_freq_b_hz;
    logic                             m_hit_a;
    logic                             m_hit_b;
    logic [1:0]                       m_direction;
    logic signed [ildd_pkg::NET_W-1:0] m_delta_count;
    logic                             m_tuning;

    inductive_loop_direction_detector_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_count_a     (s_count_a),
        .s_count_b     (s_count_b),
        .s_window_a_us (s_window_a_us),
        .s_window_b_us (s_window_b_us),
        .s_now_us      (s_now_us),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_freq_a_hz   (m_freq_a_hz),
        .m_freq_b_hz   (m_freq_b_hz),
        .m_hit_a       (m_hit_a),
        .m_hit_b       (m_hit_b),
        .m_direction   (m_direction),
        .m_delta_count (m_delta_count),
        .m_tuning      (m_tuning)
    );

    // one expected window report
    typedef struct packed {
        logic [ildd_pkg::FREQ_W-1:0] freq_a;
        logic [ildd_pkg::FREQ_W-1:0] freq_b;
        logic                        hit_a;
        logic                        hit_b;
        ildd_pkg::dir_t              dir;
        logic [ildd_pkg::NET_W-1:0]  net;
        logic                        tuning;
    } report_t;

    report_t report_q[$];

    // predictor state, mirrors the block
    logic [ildd_pkg::FREQ_W-1:0] ring_a_m [ildd_pkg::WINDOWS];
    logic [ildd_pkg::FREQ_W-1:0] ring_b_m [ildd_pkg::WINDOWS];
    int unsigned                 slot_m;
    int unsigned                 tuned_m;
    ildd_pkg::loop_t             last_loop_m;
    logic [ildd_pkg::TIME_W-1:0] last_evt_m;
    logic [ildd_pkg::TIME_W-1:0] last_chg_m;
    logic [ildd_pkg::NET_W-1:0]  net_m;
    logic [ildd_pkg::THR_W-1:0]  thr_m;
    logic [ildd_pkg::WIN_W-1:0]  stale_m;
    logic [ildd_pkg::WIN_W-1:0]  holdoff_m;
    logic                        a_entry_m;

    int  errors = 0;
    int  idle_cycles = 0;
    bit  long_hold = 1'b0;  // receiver holds off while set
    bit  burst_mode;        // sender gaps disabled while clear
    logic [ildd_pkg::TIME_W-1:0] clock_us;  // running timestamp for random items

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    function automatic logic [ildd_pkg::FREQ_W-1:0] loop_freq(
        logic [ildd_pkg::CNT_W-1:0] cnt, logic [ildd_pkg::WIN_W-1:0] win);
        logic [63:0] q;
        if (win == 0) return ildd_pkg::FREQ_MAX;
        q = (64'(cnt) * 64'd1000000) / 64'(win);
        return (q > 64'(ildd_pkg::FREQ_MAX)) ? ildd_pkg::FREQ_MAX : q[ildd_pkg::FREQ_W-1:0];
    endfunction

    // feeds one flagged loop event to the pairing logic; returns the pass direction
    function automatic ildd_pkg::dir_t pair_loop_hit(ildd_pkg::loop_t lp,
                                                     logic [ildd_pkg::TIME_W-1:0] t);
        logic [ildd_pkg::TIME_W-1:0] gap;
        logic [ildd_pkg::TIME_W-1:0] since;
        bit ok;
        ildd_pkg::dir_t d;
        gap   = t - last_evt_m;
        since = t - last_chg_m;
        d     = ildd_pkg::DIR_NONE;
        if (lp != last_loop_m && gap < ildd_pkg::TIME_W'(stale_m)) begin
            ok = since > ildd_pkg::TIME_W'(holdoff_m);
            if (ok && last_loop_m == ildd_pkg::LOOP_A && lp == ildd_pkg::LOOP_B) begin
                net_m = a_entry_m ? net_m + 1 : net_m - 1;
                d = ildd_pkg::DIR_AB;
            end else if (ok && last_loop_m == ildd_pkg::LOOP_B && lp == ildd_pkg::LOOP_A) begin
                net_m = a_entry_m ? net_m - 1 : net_m + 1;
                d = ildd_pkg::DIR_BA;
            end else begin
                // rejected pair keeps the old event time
                last_loop_m = lp;
                return ildd_pkg::DIR_NONE;
            end
            last_chg_m = t;
        end
        last_evt_m  = t;
        last_loop_m = lp;
        return d;
    endfunction

    function automatic report_t window_report(
        logic [ildd_pkg::CNT_W-1:0] ca, logic [ildd_pkg::CNT_W-1:0] cb,
        logic [ildd_pkg::WIN_W-1:0] wa, logic [ildd_pkg::WIN_W-1:0] wb,
        logic [ildd_pkg::TIME_W-1:0] t);
        report_t r;
        logic [63:0] sa, sb, thr3;
        ildd_pkg::dir_t d;
        r = '0;
        r.freq_a = loop_freq(ca, wa);
        r.freq_b = loop_freq(cb, wb);
        r.dir = ildd_pkg::DIR_NONE;
        if (tuned_m < ildd_pkg::WINDOWS) begin
            ring_a_m[tuned_m] = r.freq_a;
            ring_b_m[tuned_m] = r.freq_b;
            tuned_m++;
            if (tuned_m == ildd_pkg::WINDOWS) begin
                // last tuning value also seeds slot 0
                ring_a_m[0] = ring_a_m[ildd_pkg::WINDOWS-1];
                ring_b_m[0] = ring_b_m[ildd_pkg::WINDOWS-1];
                slot_m = 0;
            end
            r.tuning = 1'b1;
        end else begin
            sa = 0; sb = 0;
            for (int i = 0; i < ildd_pkg::WINDOWS; i++) begin
                sa += ring_a_m[i];
                sb += ring_b_m[i];
            end
            thr3 = 64'(thr_m) * ildd_pkg::WINDOWS;
            // scaled compare: freq*N > sum + thr*N
            r.hit_a = (64'(r.freq_a) * ildd_pkg::WINDOWS) > sa + thr3;
            r.hit_b = (64'(r.freq_b) * ildd_pkg::WINDOWS) > sb + thr3;
            ring_a_m[slot_m] = r.freq_a;
            ring_b_m[slot_m] = r.freq_b;
            slot_m = (slot_m + 1) % ildd_pkg::WINDOWS;
            if (r.hit_a) begin
                d = pair_loop_hit(ildd_pkg::LOOP_A, t);
                if (d != ildd_pkg::DIR_NONE) r.dir = d;
            end
            if (r.hit_b) begin
                d = pair_loop_hit(ildd_pkg::LOOP_B, t);
                if (d != ildd_pkg::DIR_NONE) r.dir = d;
            end
        end
        r.net = net_m;
        return r;
    endfunction

    // sends one window item; holds it until accepted, valid stays up between
    // back-to-back items
    task automatic send_window(logic [ildd_pkg::CNT_W-1:0] ca, logic [ildd_pkg::CNT_W-1:0] cb,
                               logic [ildd_pkg::WIN_W-1:0] wa, logic [ildd_pkg::WIN_W-1:0] wb,
                               logic [ildd_pkg::TIME_W-1:0] t);
        int gap;
        if (burst_mode && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_count_a     <= ca;
        s_count_b     <= cb;
        s_window_a_us <= wa;
        s_window_b_us <= wb;
        s_now_us      <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        report_q.push_back(window_report(ca, cb, wa, wb, t));
    endtask

    task automatic write_reg(logic [1:0] idx, logic [ildd_pkg::CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        case (idx)
            ildd_pkg::REG_THRESHOLD: thr_m     = val[ildd_pkg::THR_W-1:0];
            ildd_pkg::REG_STALE:     stale_m   = val;
            ildd_pkg::REG_HOLDOFF:   holdoff_m = val;
            ildd_pkg::REG_A_ENTRY:   a_entry_m = val[0];
            default: ;
        endcase
    endtask

    // block is idle once every report is back plus its latency
    task automatic drain;
        s_valid <= 1'b0;
        while (report_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    // quiet baseline window on both loops
    task automatic send_quiet(logic [ildd_pkg::TIME_W-1:0] t);
        send_window(15'd1000, 15'd1000, 24'd100000, 24'd100000, t);
    endtask

    task automatic test_tuning_and_extremes;
        // tuning with zero windows, full counts and all-zero items
        send_window('0, '0, '0, '0, '0);
        send_window('1, '1, '1, '1, '1);
        send_window(15'd1000, 15'd1000, 24'd100000, 24'd100000, 48'd0);
        // after tuning: saturation via zero window and huge quotient
        send_window(15'd1000, '1, 24'd100000, 24'd1, 48'd10);
        send_window(15'd1000, 15'd1000, 24'd0, 24'd100000, 48'd20);
        send_window('1, '0, '1, '1, '1);
        drain();
    endtask

    // A then B, B then A, stale pair, holdoff rejection, timestamp wrap
    task automatic test_direction_pairs;
        logic [ildd_pkg::TIME_W-1:0] t;
        t = 48'd5_000_000;
        for (int k = 0; k < 4; k++) send_quiet(t);
        send_window(15'd5000, 15'd1000, 24'd100000, 24'd100000, t);            // A hit
        send_window(15'd1000, 15'd5000, 24'd100000, 24'd100000, t + 500_000);  // pass
        for (int k = 0; k < 3; k++) send_quiet(t);
        send_window(15'd1000, 15'd5000, 24'd100000, 24'd100000, t + 1_000_000);
        send_window(15'd5000, 15'd1000, 24'd100000, 24'd100000, t + 1_100_000); // B then A pass
        send_window(15'd1000, 15'd5000, 24'd100000, 24'd100000, t + 9_000_000); // stale
        send_window(15'd5000, 15'd5000, 24'd100000, 24'd100000, t + 9_500_000); // both
        send_window(15'd5000, 15'd1000, 24'd100000, 24'd100000, 48'hFFFF_FFFF_FFF0);
        send_window(15'd1000, 15'd5000, 24'd100000, 24'd100000, 48'd10); // wraps
        drain();
    endtask

    task automatic test_config_extremes;
        write_reg(ildd_pkg::REG_THRESHOLD, 24'd0);
        write_reg(ildd_pkg::REG_STALE, 24'hFFFFFF);
        write_reg(ildd_pkg::REG_HOLDOFF, 24'd0);
        write_reg(ildd_pkg::REG_A_ENTRY, 24'd0);
        for (int k = 0; k < 6; k++)
            send_window(k[0] ? 15'd3000 : 15'd1000, k[0] ? 15'd1000 : 15'd3000,
                        24'd100000, 24'd100000, 48'd100 * k);
        drain();
        write_reg(ildd_pkg::REG_THRESHOLD, 24'hFFFF);
        write_reg(ildd_pkg::REG_STALE, 24'd0);
        write_reg(ildd_pkg::REG_HOLDOFF, 24'hFFFFFF);
        write_reg(ildd_pkg::REG_A_ENTRY, 24'd1);
        send_window('1, '1, 24'd1, 24'd1, 48'd1);
        drain();
    endtask

    // random pass sequences mixed with noise items
    task automatic random_phase(int n);
        int pick;
        int unsigned ca, cb;
        for (int i = 0; i < n; i++) begin
            clock_us += $urandom_range(0, 400_000);
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                ca = $urandom_range(900, 1100) + (($urandom_range(0, 2) == 0) ? 900 : 0);
                cb = $urandom_range(900, 1100) + (($urandom_range(0, 2) == 0) ? 900 : 0);
                send_window(15'(ca), 15'(cb),
                            24'($urandom_range(99000, 101000)),
                            24'($urandom_range(99000, 101000)), clock_us);
            end else if (pick < 9) begin
                send_window(15'($urandom), 15'($urandom), 24'($urandom), 24'($urandom),
                            48'({$urandom, $urandom}));
            end else begin
                send_window(15'($urandom), 15'($urandom),
                            24'($urandom_range(0, 3)), 24'($urandom_range(0, 70)), clock_us);
            end
        end
        drain();
    endtask

    task automatic test_random;
        random_phase(300);
        write_reg(ildd_pkg::REG_THRESHOLD, 24'($urandom_range(0, 400)));
        write_reg(ildd_pkg::REG_STALE, 24'($urandom_range(200_000, 3_000_000)));
        write_reg(ildd_pkg::REG_HOLDOFF, 24'($urandom_range(0, 400_000)));
        write_reg(ildd_pkg::REG_A_ENTRY, 24'($urandom_range(0, 1)));
        random_phase(300);
        write_reg(ildd_pkg::REG_THRESHOLD, 24'd150);
        write_reg(ildd_pkg::REG_STALE, 24'd2_000_000);
        write_reg(ildd_pkg::REG_HOLDOFF, 24'd250_000);
        write_reg(ildd_pkg::REG_A_ENTRY, 24'd0);
        burst_mode = 1'b0;  // back-to-back stretch
        random_phase(100);
        burst_mode = 1'b1;
        random_phase(200);
    endtask

    // receiver blocks for a long stretch while the sender keeps offering items
    task automatic test_backpressure;
        long_hold = 1'b1;
        for (int k = 0; k < 8; k++) begin
            clock_us += 100_000;
            send_quiet(clock_us);
        end
        drain();
    endtask

    // stall pattern: bursts of ready, occasional long hold
    initial begin
        int hold_cnt;
        m_ready = 1'b0;
        hold_cnt = 0;
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_ready <= 1'b0;
                hold_cnt++;
                if (hold_cnt >= 400) begin
                    long_hold = 1'b0;
                    hold_cnt = 0;
                end
            end else
                m_ready <= ($urandom_range(0, 4) != 0);
        end
    end

    // result checker
    always @(posedge aclk) begin
        report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (report_q.size() == 0) begin
                $display("%0t: unexpected result item", $time);
                errors++;
            end else begin
                want = report_q.pop_front();
                if (m_freq_a_hz !== want.freq_a) begin
                    $display("%0t: freq_a exp %0d got %0d", $time, want.freq_a, m_freq_a_hz);
                    errors++;
                end
                if (m_freq_b_hz !== want.freq_b) begin
                    $display("%0t: freq_b exp %0d got %0d", $time, want.freq_b, m_freq_b_hz);
                    errors++;
                end
                if (m_hit_a !== want.hit_a) begin
                    $display("%0t: hit_a exp %0d got %0d", $time, want.hit_a, m_hit_a);
                    errors++;
                end
                if (m_hit_b !== want.hit_b) begin
                    $display("%0t: hit_b exp %0d got %0d", $time, want.hit_b, m_hit_b);
                    errors++;
                end
                if (m_direction !== want.dir) begin
                    $display("%0t: direction exp %0d got %0d", $time, want.dir, m_direction);
                    errors++;
                end
                if (m_delta_count !== want.net) begin
                    $display("%0t: delta exp %0d got %0d", $time,
                             $signed(want.net), m_delta_count);
                    errors++;
                end
                if (m_tuning !== want.tuning) begin
                    $display("%0t: tuning exp %0d got %0d", $time, want.tuning, m_tuning);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        burst_mode    = 1'b1;
        clock_us      = 48'd0;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = ildd_pkg::REG_THRESHOLD;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_count_a     = '0;
        s_count_b     = '0;
        s_window_a_us = '0;
        s_window_b_us = '0;
        s_now_us      = '0;
        for (int i = 0; i < ildd_pkg::WINDOWS; i++) begin
            ring_a_m[i] = '0;
            ring_b_m[i] = '0;
        end
        slot_m      = 0;
        tuned_m     = 0;
        last_loop_m = ildd_pkg::LOOP_NONE;
        last_evt_m  = '0;
        last_chg_m  = '0;
        net_m       = '0;
        thr_m       = 16'd150;
        stale_m     = 24'd2_000_000;
        holdoff_m   = 24'd250_000;
        a_entry_m   = 1'b1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_tuning_and_extremes();
        test_direction_pairs();
        test_config_extremes();
        test_backpressure();
        test_random();
        drain();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
